>>> rtl/core/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg: shared types and constants of the postfix expression evaluator
// Holds the character codes, the operator decode and the flag record.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam int WORD_W    = 32;
   localparam int CHAR_W    = 8;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

   // Value returned by a pop from an empty stack.
   localparam logic [WORD_W-1:0] EMPTY_POP_VALUE = '1;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic under;
      logic over;
      logic inval;
      logic div0;
   } flags_type;

   function automatic op_type decode_op(input logic [CHAR_W-1:0] code);
      op_type op;
      case (code)
         CHAR_PLUS:  op = OP_ADD;
         CHAR_MINUS: op = OP_SUB;
         CHAR_STAR:  op = OP_MUL;
         CHAR_SLASH: op = OP_DIV;
         default:    op = OP_BAD;
      endcase
      return op;
   endfunction

endpackage

>>> rtl/core/pee_req_if.sv
// ----------------------------------------------------------------------------
// pee_req_if: request channel of the postfix expression evaluator
// Carries one expression character and its end-of-expression mark.
// ----------------------------------------------------------------------------
interface pee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> rtl/core/pee_rsp_if.sv
// ----------------------------------------------------------------------------
// pee_rsp_if: response channel of the postfix expression evaluator
// Carries the final value of an expression and its sticky error flags.
// ----------------------------------------------------------------------------
interface pee_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               underflow_seen;
   logic               overflow_seen;
   logic               invalid_seen;
   logic               divide_by_zero;

   modport source (output valid, output value, output underflow_seen,
                   output overflow_seen, output invalid_seen,
                   output divide_by_zero, input ready);
   modport sink   (input valid, input value, input underflow_seen,
                   input overflow_seen, input invalid_seen,
                   input divide_by_zero, output ready);
endinterface

>>> rtl/core/postfix_expression_evaluator.sv
// A digit is pushed from idle; any other character pops two operands, and
// '+', '-', '*' and '/' push a result ('/' via the one-bit-per-cycle restoring
// divider unless the divisor is zero). A last character adds the final pop and
// a registered response once the output register is free. One transaction is in work at a time.
// Reset (synchronous) empties the stack and clears the flags; the stack
// memory itself is not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: single-digit postfix evaluator
// A small sequencer drives a stack memory, an adder, subtractor and multiplier, an
// iterative divider, and emits one response per expression.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pee_pkg::*; #(
   parameter int STACK_DEPTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   pee_req_if.sink   req_if,
   pee_rsp_if.source rsp_if
);

   // The count must hold the depth itself; the index only addresses entries.
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // One-hot sequencer states.
   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_POP_R   = 9'b000000010,
      ST_POP_L   = 9'b000000100,
      ST_EXEC    = 9'b000001000,
      ST_DIV     = 9'b000010000,
      ST_DIV_END = 9'b000100000,
      ST_PUSH    = 9'b001000000,
      ST_FIN_RD  = 9'b010000000,
      ST_FIN_OUT = 9'b100000000
   } state_type;

   // Control registers.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   flags_type            flags_ff, flags_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic                 last_ff, last_in;
   op_type               op_ff, op_in;
   logic                 empty_ff, empty_in;
   logic [WORD_W-1:0]    rhs_ff, rhs_in;
   logic [WORD_W-1:0]    result_ff, result_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    quo_ff, quo_in;
   logic [WORD_W-1:0]    dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [WORD_W-1:0]    rsp_value_ff, rsp_value_in;
   flags_type            rsp_flags_ff, rsp_flags_in;

   // Stack memory with a registered read port.
   logic [WORD_W-1:0]    stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 mem_we;
   logic                 mem_re;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic [WORD_W-1:0]    wr_data;

   // Shared requests to the push and pop logic.
   logic                 push_req;
   logic [WORD_W-1:0]    push_data;
   logic                 pop_req;

   logic [CNT_W-1:0]     count_dec;
   logic                 stack_full;
   logic                 stack_empty;
   logic [WORD_W-1:0]    pop_val;
   logic                 is_digit;
   logic                 rsp_free;
   logic [WORD_W:0]      div_trial;

   assign count_dec   = count_ff - CNT_W'(1);
   assign stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign rd_addr     = count_dec[IDX_W-1:0];
   assign wr_addr     = count_ff[IDX_W-1:0];
   assign wr_data     = push_data;

   // The value of the most recent pop: the word read, or the empty marker.
   assign pop_val   = empty_ff ? EMPTY_POP_VALUE : rd_data_ff;
   assign is_digit  = req_if.char_code inside {[CHAR_ZERO:CHAR_NINE]};
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;

   // Restoring division step: shift the next dividend bit into the
   // remainder and try to subtract the divisor.
   assign div_trial = {rem_ff, quo_ff[WORD_W-1]} - {1'b0, dvs_ff};

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.value          = rsp_value_ff;
   assign rsp_if.underflow_seen = rsp_flags_ff.under;
   assign rsp_if.overflow_seen  = rsp_flags_ff.over;
   assign rsp_if.invalid_seen   = rsp_flags_ff.inval;
   assign rsp_if.divide_by_zero = rsp_flags_ff.div0;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      op_in        = op_ff;
      empty_in     = empty_ff;
      rhs_in       = rhs_ff;
      result_in    = result_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_value_in = rsp_value_ff;
      rsp_flags_in = rsp_flags_ff;
      push_req     = 1'b0;
      push_data    = result_ff;
      pop_req      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      // A response that has been taken frees the output register.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               last_in = req_if.last_char;
               op_in   = decode_op(req_if.char_code);
               if (is_digit) begin
                  // The low nibble of an ASCII digit is its value.
                  push_req  = 1'b1;
                  push_data = {{(WORD_W-4){1'b0}}, req_if.char_code[3:0]};
                  state_in  = req_if.last_char ? ST_FIN_RD : ST_IDLE;
               end else begin
                  state_in = ST_POP_R;
               end
            end
         end
         ST_POP_R: begin
            pop_req  = 1'b1;
            state_in = ST_POP_L;
         end
         ST_POP_L: begin
            rhs_in   = pop_val;
            pop_req  = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_ADD: begin
                  result_in = pop_val + rhs_ff;
                  state_in  = ST_PUSH;
               end
               OP_SUB: begin
                  result_in = pop_val - rhs_ff;
                  state_in  = ST_PUSH;
               end
               OP_MUL: begin
                  result_in = pop_val * rhs_ff;
                  state_in  = ST_PUSH;
               end
               OP_DIV: begin
                  if (rhs_ff == '0) begin
                     flags_in.div0 = 1'b1;
                     result_in     = '0;
                     state_in      = ST_PUSH;
                  end else begin
                     // Divide magnitudes; the sign is applied at the end.
                     neg_in     = pop_val[WORD_W-1] ^ rhs_ff[WORD_W-1];
                     quo_in     = pop_val[WORD_W-1] ? -pop_val : pop_val;
                     dvs_in     = rhs_ff[WORD_W-1] ? -rhs_ff : rhs_ff;
                     rem_in     = '0;
                     div_cnt_in = '0;
                     state_in   = ST_DIV;
                  end
               end
               default: begin
                  // Both operands are discarded and nothing is pushed.
                  flags_in.inval = 1'b1;
                  state_in       = last_ff ? ST_FIN_RD : ST_IDLE;
               end
            endcase
         end
         ST_DIV: begin
            if (!div_trial[WORD_W]) begin
               rem_in = div_trial[WORD_W-1:0];
            end else begin
               rem_in = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
            end
            quo_in     = {quo_ff[WORD_W-2:0], !div_trial[WORD_W]};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            // The most negative value over -1 wraps back onto itself here.
            result_in = neg_ff ? -quo_ff : quo_ff;
            state_in  = ST_PUSH;
         end
         ST_PUSH: begin
            push_req = 1'b1;
            state_in = last_ff ? ST_FIN_RD : ST_IDLE;
         end
         ST_FIN_RD: begin
            pop_req  = 1'b1;
            state_in = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pop_val;
               rsp_flags_in = flags_ff;
               count_in     = '0;
               flags_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A push onto a full stack is dropped and noted.
      if (push_req) begin
         if (stack_full) begin
            flags_in.over = 1'b1;
         end else begin
            mem_we   = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
      end

      // A pop from an empty stack yields the empty marker and is noted.
      if (pop_req) begin
         if (stack_empty) begin
            empty_in       = 1'b1;
            flags_in.under = 1'b1;
         end else begin
            empty_in = 1'b0;
            mem_re   = 1'b1;
            count_in = count_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      op_ff        <= op_in;
      empty_ff     <= empty_in;
      rhs_ff       <= rhs_in;
      result_ff    <= result_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvs_ff       <= dvs_in;
      neg_ff       <= neg_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   // Stack memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

endmodule
